FILE: rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// shared types, constants and the byte-wide crc step of the checksum engine
// ----------------------------------------------------------------------------
package tce_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] LENGTH_INIT = 32'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] crc_value;
      logic [31:0] sum_value;
      logic [31:0] nonzero_total;
      logic [31:0] bytes_seen;
   } rsp_type;

   typedef enum logic [0:0] {
      OP_START,
      OP_BYTE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } queue_entry_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/tce_front.sv
// ----------------------------------------------------------------------------
// tce_front
// accepts requests, holds the length register and classifies requests into
// queue operations; zero-length starts are dropped here
// ----------------------------------------------------------------------------
module tce_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tce_pkg::req_type         req_data,
   input  logic                     csr_wr_en,
   input  logic [31:0]              csr_wr_data,
   input  logic                     queue_full,
   output logic                     push,
   output tce_pkg::queue_entry_type push_entry,
   output logic [31:0]              tensor_length
);

   logic [31:0] length_ff;
   logic [31:0] length_in;
   logic        keep;

   always_comb begin
      length_in = csr_wr_en ? csr_wr_data : length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= tce_pkg::LENGTH_INIT;
      end else begin
         length_ff <= length_in;
      end
   end

   // classify
   always_comb begin
      keep                 = 1'b0;
      push_entry.op        = tce_pkg::OP_BYTE;
      push_entry.data_byte = req_data.data_byte;
      unique case (req_data.kind)
         tce_pkg::KIND_START: begin
            keep          = (length_ff != 32'd0);
            push_entry.op = tce_pkg::OP_START;
         end
         tce_pkg::KIND_BYTE: begin
            keep          = 1'b1;
            push_entry.op = tce_pkg::OP_BYTE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready     = !queue_full;
   assign push          = req_valid && req_ready && keep;
   assign tensor_length = length_ff;

endmodule

FILE: rtl/core/tce_queue.sv
// ----------------------------------------------------------------------------
// tce_queue
// short fifo of classified operations between front and back
// ----------------------------------------------------------------------------
module tce_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tce_pkg::queue_entry_type push_entry,
   input  logic                     pop,
   output tce_pkg::queue_entry_type head_entry,
   output logic                     full,
   output logic                     empty
);

   tce_pkg::queue_entry_type mem_ff [tce_pkg::QUEUE_DEPTH];

   logic [tce_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tce_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tce_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [tce_pkg::QPTR_W-1:0] PTR_LAST = tce_pkg::QPTR_W'(tce_pkg::QUEUE_DEPTH - 1);
   localparam logic [tce_pkg::QCNT_W-1:0] CNT_FULL = tce_pkg::QCNT_W'(tce_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == CNT_FULL);
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/tce_back.sv
// ----------------------------------------------------------------------------
// tce_back
// runs the accumulators on queued operations and holds the result register
// ----------------------------------------------------------------------------
module tce_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  tce_pkg::queue_entry_type head_entry,
   output logic                     pop,
   input  logic [31:0]              tensor_length,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tce_pkg::rsp_type         rsp_data
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] nz_ff, nz_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        armed_ff, armed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tce_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] crc_next, sum_next, nz_next, cnt_next;

   assign pop = !empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      crc_next = tce_pkg::crc_byte(crc_ff, head_entry.data_byte);
      sum_next = sum_ff + {24'd0, head_entry.data_byte};
      nz_next  = nz_ff + {31'd0, (head_entry.data_byte != 8'd0)};
      cnt_next = cnt_ff + 32'd1;
   end

   always_comb begin
      crc_in       = crc_ff;
      sum_in       = sum_ff;
      nz_in        = nz_ff;
      cnt_in       = cnt_ff;
      armed_in     = armed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         case (head_entry.op)
            tce_pkg::OP_START: begin
               crc_in   = tce_pkg::CRC_ONES;
               sum_in   = '0;
               nz_in    = '0;
               cnt_in   = '0;
               armed_in = 1'b1;
            end
            tce_pkg::OP_BYTE: begin
               if (armed_ff) begin
                  crc_in = crc_next;
                  sum_in = sum_next;
                  nz_in  = nz_next;
                  cnt_in = cnt_next;
                  if (cnt_next >= tensor_length) begin
                     armed_in                  = 1'b0;
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.crc_value     = crc_next ^ tce_pkg::CRC_ONES;
                     rsp_data_in.sum_value     = sum_next;
                     rsp_data_in.nonzero_total = nz_next;
                     rsp_data_in.bytes_seen    = cnt_next;
                  end
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= tce_pkg::CRC_ONES;
         sum_ff       <= '0;
         nz_ff        <= '0;
         cnt_ff       <= '0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         sum_ff       <= sum_in;
         nz_ff        <= nz_in;
         cnt_ff       <= cnt_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_result_needs_armed: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(armed_ff))
      else $error("result raised while idle");

   a_disarm_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(armed_ff) |-> rsp_valid_ff)
      else $error("run ended without a result");

   a_nonzero_within_count: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (nz_ff <= cnt_ff))
      else $error("nonzero count above byte count");

   a_result_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.bytes_seen != 32'd0))
      else $error("result with zero bytes");
`endif

endmodule

FILE: rtl/core/tensor_checksum_engine.sv
// ----------------------------------------------------------------------------
// tensor_checksum_engine
// crc-32, byte sum and byte counts over one tensor run per start request
// ----------------------------------------------------------------------------
//   channel  | ports                         | payload
//   ---------+-------------------------------+------------------------------
//   request  | req_valid / req_ready         | req_data  (kind, data_byte)
//   response | rsp_valid / rsp_ready         | rsp_data  (crc, sum, counts)
//   csr      | csr_wr_en                     | csr_wr_data (tensor_length)
//
// one request per cycle sustained while responses are taken; a run's last byte
// passes the queue stage, then the accumulator/result register
// while a response stalls the four-entry queue absorbs up to four more
// requests, then req_ready drops until the response is taken
// synchronous reset clears the queue, disarms the engine, length back to 1
// ----------------------------------------------------------------------------
module tensor_checksum_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tce_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tce_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   logic                     queue_full;
   logic                     queue_empty;
   logic                     push;
   logic                     pop;
   tce_pkg::queue_entry_type push_entry;
   tce_pkg::queue_entry_type head_entry;
   logic [31:0]              tensor_length;

   tce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry),
      .tensor_length (tensor_length)
   );

   tce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   tce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (queue_empty),
      .head_entry    (head_entry),
      .pop           (pop),
      .tensor_length (tensor_length),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule
